### sv/mfb_pkg.sv
// shared types, constants and the crc step for the modbus frame builder
`timescale 1ns / 1ps

package mfb_pkg;

  localparam int BatchBytes  = 32;
  localparam int HeaderBytes = 6;
  localparam int FrameBytes  = HeaderBytes + BatchBytes + 2;
  localparam int JobDepth    = 2;

  localparam int IdxW   = $clog2(BatchBytes);
  localparam int LenW   = $clog2(BatchBytes + 1);
  localparam int KW     = $clog2(FrameBytes);
  localparam int MemAw  = IdxW + 1;
  localparam int JobPw  = $clog2(JobDepth);
  localparam int JobCw  = $clog2(JobDepth + 1);
  localparam int PaddrW = 3;

  localparam logic [7:0]  FuncWriteMulti = 8'h10;
  localparam logic [15:0] RegCount       = 16'h0010;
  localparam logic [7:0]  PadByte        = 8'hff;
  localparam logic [15:0] CrcInit        = 16'hffff;
  localparam logic [15:0] CrcPoly        = 16'ha001;

  localparam logic RegSlaveAddress = 1'b0;
  localparam logic RegStartAddress = 1'b1;

  // one closed batch waiting for the sender
  typedef struct packed {
    logic            bank;
    logic [LenW-1:0] len;
  } job_t;

  // payload memory write port
  typedef struct packed {
    logic             en;
    logic [MemAw-1:0] addr;
    logic [7:0]       data;
  } wr_t;

  // configuration seen by the sender
  typedef struct packed {
    logic [7:0]  slave_address;
    logic        addr_load;
    logic [15:0] start_address;
  } cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### sv/mfb_front.sv
// batch collector: writes octets into the free payload bank and closes batches
`timescale 1ns / 1ps

module mfb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [7:0]          data_byte_i,
  input  logic                final_byte_i,
  output logic                full_o,
  input  logic                jobq_full_i,
  output logic                job_push_o,
  output mfb_pkg::job_t       job_o,
  output mfb_pkg::wr_t        wr_o
);
  import mfb_pkg::*;

  logic [LenW-1:0] fill_q, fill_d;
  logic            bank_q, bank_d;
  logic [LenW-1:0] fill_inc;
  logic            take;
  logic            close;

  assign full_o   = jobq_full_i;
  assign take     = push_i && !jobq_full_i;
  assign fill_inc = fill_q + 1'b1;
  assign close    = final_byte_i || (fill_inc == LenW'(BatchBytes));

  assign wr_o.en   = take;
  assign wr_o.addr = {bank_q, fill_q[IdxW-1:0]};
  assign wr_o.data = data_byte_i;

  assign job_push_o = take && close;
  assign job_o.bank = bank_q;
  assign job_o.len  = fill_inc;

  always_comb begin
    fill_d = fill_q;
    bank_d = bank_q;
    if (take) begin
      if (close) begin
        fill_d = '0;
        bank_d = !bank_q;
      end else begin
        fill_d = fill_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bank_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      bank_q <= bank_d;
    end
  end

endmodule

### sv/mfb_jobq.sv
// short queue of closed batches between collector and sender
`timescale 1ns / 1ps

module mfb_jobq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mfb_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output mfb_pkg::job_t head_o
);
  import mfb_pkg::*;

  job_t             slot_q [JobDepth];
  logic [JobPw-1:0] wr_q, wr_d;
  logic [JobPw-1:0] rd_q, rd_d;
  logic [JobCw-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == JobCw'(JobDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == JobPw'(JobDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == JobPw'(JobDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### sv/mfb_back.sv
// frame sender: payload memory, byte sequencer, running crc and output register
`timescale 1ns / 1ps

module mfb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mfb_pkg::wr_t  wr_i,
  input  mfb_pkg::cfg_t cfg_i,
  input  logic          job_valid_i,
  input  mfb_pkg::job_t job_i,
  output logic          job_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [7:0]    frame_byte_o,
  output logic          frame_end_o
);
  import mfb_pkg::*;

  localparam logic [KW-1:0] KHead   = KW'(HeaderBytes);
  localparam logic [KW-1:0] KCrcLo  = KW'(FrameBytes - 2);
  localparam logic [KW-1:0] KLast   = KW'(FrameBytes - 1);

  logic [7:0]       mem_q [2 * BatchBytes];
  logic [7:0]       rdata_q;

  logic [KW-1:0]    k_q, k_d;
  logic [15:0]      crc_q, crc_d;
  logic [15:0]      faddr_q, faddr_d;
  logic             ov_q, ov_d;
  logic [7:0]       ob_q, ob_d;
  logic             oe_q, oe_d;

  logic             adv;
  logic             last;
  logic [KW-1:0]    k_nxt;
  logic [KW-1:0]    k_off;
  logic [KW-1:0]    nk_off;
  logic [7:0]       cur_byte;

  assign adv       = job_valid_i && (!ov_q || pop_i);
  assign last      = (k_q == KLast);
  assign job_pop_o = adv && last;
  assign k_nxt     = !adv ? k_q : (last ? '0 : k_q + 1'b1);
  assign k_off     = k_q - KHead;
  assign nk_off    = k_nxt - KHead;

  assign empty_o      = !ov_q;
  assign frame_byte_o = ob_q;
  assign frame_end_o  = oe_q;

  always_comb begin
    if (k_q == KW'(0)) begin
      cur_byte = cfg_i.slave_address;
    end else if (k_q == KW'(1)) begin
      cur_byte = FuncWriteMulti;
    end else if (k_q == KW'(2)) begin
      cur_byte = faddr_q[15:8];
    end else if (k_q == KW'(3)) begin
      cur_byte = faddr_q[7:0];
    end else if (k_q == KW'(4)) begin
      cur_byte = RegCount[15:8];
    end else if (k_q == KW'(5)) begin
      cur_byte = RegCount[7:0];
    end else if (k_q == KCrcLo) begin
      cur_byte = crc_q[7:0];
    end else if (k_q == KLast) begin
      cur_byte = crc_q[15:8];
    end else if (KW'(job_i.len) > k_off) begin
      cur_byte = rdata_q;
    end else begin
      cur_byte = PadByte;
    end
  end

  always_comb begin
    k_d     = k_nxt;
    crc_d   = crc_q;
    faddr_d = faddr_q;
    ov_d    = ov_q && !pop_i;
    ob_d    = ob_q;
    oe_d    = oe_q;
    if (adv) begin
      ov_d = 1'b1;
      ob_d = cur_byte;
      oe_d = last;
      if (last) begin
        crc_d   = CrcInit;
        faddr_d = faddr_q + 16'(BatchBytes);
      end else if (k_q < KCrcLo) begin
        crc_d = crc_byte(crc_q, cur_byte);
      end
    end
    if (cfg_i.addr_load) begin
      faddr_d = cfg_i.start_address;
    end
  end

  // one write port from the collector, one registered read port ahead of the sequencer
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[{job_i.bank, nk_off[IdxW-1:0]}];
    ob_q    <= ob_d;
    oe_q    <= oe_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      crc_q   <= CrcInit;
      faddr_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      k_q     <= k_d;
      crc_q   <= crc_d;
      faddr_q <= faddr_d;
      ov_q    <= ov_d;
    end
  end

endmodule

### sv/modbus_flash_frame_builder_core.sv
// top level of the modbus flash frame builder: register port, collector, queue, sender
`timescale 1ns / 1ps
// first frame byte: the batch closed by an octet passes the job queue register, then the
// output register; a frame of 40 bytes then leaves at one byte per cycle while the reader pops every byte
// throughput: one octet per cycle while a payload bank is free; two banks let one batch
// fill while the other is sent, so over a long run the sender sets the octet rate
// reset: asynchronous, clears counters, queue and registers; no clearing pass is needed

module modbus_flash_frame_builder_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // octet input, queue style
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 data_byte_i,
  input  logic                       final_byte_i,
  // frame byte output, queue style
  output logic                       empty,
  input  logic                       pop,
  output logic [7:0]                 frame_byte_o,
  output logic                       frame_end_o,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mfb_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import mfb_pkg::*;

  logic [7:0]  slave_q, slave_d;
  logic [15:0] start_q, start_d;
  logic        wr_en;
  logic        reg_sel;

  cfg_t        cfg;
  wr_t         mem_wr;
  job_t        job_in;
  job_t        job_head;
  logic        job_push;
  logic        job_pop;
  logic        jobq_full;
  logic        job_valid;

  // registers sit at byte addresses 0 and 4, so bit 2 picks one
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    slave_d = slave_q;
    start_d = start_q;
    if (wr_en) begin
      unique case (reg_sel)
        RegSlaveAddress: slave_d = pwdata[7:0];
        RegStartAddress: start_d = pwdata[15:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegSlaveAddress: prdata = {24'h000000, slave_q};
      RegStartAddress: prdata = {16'h0000, start_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q <= 8'h01;
      start_q <= '0;
    end else begin
      slave_q <= slave_d;
      start_q <= start_d;
    end
  end

  // a start address write also loads the sender's frame address counter with the new address
  assign cfg.slave_address = slave_q;
  assign cfg.addr_load     = wr_en && (reg_sel == RegStartAddress);
  assign cfg.start_address = pwdata[15:0];

  // front: collects octets into the free bank and closes batches
  mfb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .full_o       (full),
    .jobq_full_i  (jobq_full),
    .job_push_o   (job_push),
    .job_o        (job_in),
    .wr_o         (mem_wr)
  );

  // closed batches wait here; full when both banks are taken
  mfb_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .pop_i   (job_pop),
    .full_o  (jobq_full),
    .valid_o (job_valid),
    .head_o  (job_head)
  );

  // back: builds header, payload with padding and crc, one byte per transfer
  mfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (mem_wr),
    .cfg_i        (cfg),
    .job_valid_i  (job_valid),
    .job_i        (job_head),
    .job_pop_o    (job_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .frame_byte_o (frame_byte_o),
    .frame_end_o  (frame_end_o)
  );

endmodule
